// ----- sv/bayer_near_ceiling_stats_assert.svh -----
// Assertion macros for the near-ceiling statistics block.
`ifndef BAYER_NEAR_CEILING_STATS_ASSERT_SVH
`define BAYER_NEAR_CEILING_STATS_ASSERT_SVH
`ifndef SYNTHESIS
`define BNCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BNCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BNCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BNCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/bncs_pkg.sv -----
// Package: types, constants and helpers for the near-ceiling statistics block.
package bncs_pkg;
    localparam int CNT_W = 23;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int FRAC_W = 16;
    localparam int MAX_DIM = 4096;
    localparam int NUM_POS = 4;
    localparam int QUO_W = CNT_W + FRAC_W;

    typedef enum logic [2:0] {
        REG_GATE_LEFT = 3'd0,
        REG_GATE_TOP  = 3'd1,
        REG_GATE_COLS = 3'd2,
        REG_GATE_ROWS = 3'd3,
        REG_THR0      = 3'd4,
        REG_THR1      = 3'd5,
        REG_THR2      = 3'd6,
        REG_THR3      = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       count_en;
        logic       capture_last;
        logic       load_div;
        logic       store_q;
        logic       clear;
        logic       out_load;
        logic [1:0] pos;
        logic [1:0] ratio_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } sts_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction
endpackage

// ----- sv/bayer_near_ceiling_stats.sv -----
// Top level of the Bayer near-ceiling statistics block.
// Pixels are taken one per clock while the frame accumulates; each accepted
// pixel bumps the frame counters of its CFA position, and its gate counters
// if it lies in the gate, in that same cycle. On the last pixel the block
// stops accepting and computes sixteen ratios, four per position, with one
// shared restoring divider, one quotient bit per cycle (a load, the quotient
// bits, a store); after a position's four ratios it loads its result into
// the output register and steps on, positions 0 to 3. No pixel of the next
// frame is accepted before the last result is loaded, and a load waits while
// the output holds a result not yet taken on m_axis_tready. The output
// register frees the datapath as soon as a result sits in it; geometry
// failures report status 1 with zero fractions and all undefined flags set.
`include "bayer_near_ceiling_stats_assert.svh"
module bayer_near_ceiling_stats
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_col[11:0], pixel_row[23:12], pixel_value[39:24], sample_valid[40], zero pad
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,  // last_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cfa_position[1:0], near_fraction_frame[17:2], near_fraction_gate[33:18],
    // valid_fraction_frame[49:34], valid_fraction_gate[65:50],
    // near_frame_undefined[66], near_gate_undefined[67],
    // valid_frame_undefined[68], valid_gate_undefined[69], zero pad
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser,  // status
    output logic        m_axis_tlast   // last_result
);
    bncs_pkg::cmd_t cmd;
    bncs_pkg::sts_t sts;
    logic in_fire, out_set, ovalid_reg, out_free;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !ovalid_reg || m_axis_tready;

    bncs_control u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_last  (s_axis_tlast),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_axis_tready),
        .out_set  (out_set)
    );

    bncs_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_col    (s_axis_tdata[11:0]),
        .pixel_row    (s_axis_tdata[23:12]),
        .pixel_value  (s_axis_tdata[39:24]),
        .sample_valid (s_axis_tdata[40]),
        .out_data     (m_axis_tdata),
        .out_user     (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

    // output valid: set on a load, cleared when the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_set)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end
    assign m_axis_tvalid = ovalid_reg;

    // no pixel accepted while a result is loaded
    `BNCS_ASSERT_IMPL(a_no_in_on_load, clk, rst_n, out_set, !in_fire)
    // a load only happens when the output slot is free
    `BNCS_ASSERT_IMPL(a_load_free, clk, rst_n, out_set, out_free)
    // a loaded result is presented next cycle
    `BNCS_ASSERT_NEXT(a_load_valid, clk, rst_n, out_set, m_axis_tvalid)
endmodule

// ----- sv/bncs_divider.sv -----
// Restoring divider: one quotient bit per cycle, saturated Q0.16 result.
module bncs_divider
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bncs_pkg::CNT_W-1:0]          num,
    input  logic [bncs_pkg::CNT_W-1:0]          den,
    output logic                                done,
    output logic [bncs_pkg::FRAC_W-1:0]         quo,
    output logic                                undef
);
    localparam int QW = bncs_pkg::QUO_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]           dvd_reg, dvd_next;
    logic [bncs_pkg::CNT_W:0] rem_reg, rem_next;
    logic [bncs_pkg::CNT_W-1:0] den_reg;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic [bncs_pkg::CNT_W:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[bncs_pkg::CNT_W-1:0], dvd_reg[QW-1]};
        if (start)
        begin
            dvd_next  = {num, {bncs_pkg::FRAC_W{1'b0}}};
            rem_next  = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                dvd_next = {dvd_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign done  = !busy_reg && !start;
    assign undef = (den_reg == '0);
    assign quo   = undef ? '0 :
                   (|dvd_reg[QW-1:bncs_pkg::FRAC_W]) ? '1 : dvd_reg[bncs_pkg::FRAC_W-1:0];
endmodule

// ----- sv/bncs_datapath.sv -----
// Datapath: configuration registers, counters, geometry check, divider, output register.
module bncs_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bncs_pkg::cmd_t                cmd,
    output bncs_pkg::sts_t                sts,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic [11:0]                   pixel_col,
    input  logic [11:0]                   pixel_row,
    input  logic [15:0]                   pixel_value,
    input  logic                          sample_valid,
    output logic [71:0]                   out_data,
    output logic                          out_user,
    output logic                          out_last
);
    localparam int CW = bncs_pkg::CNT_W;

    logic [11:0] gate_left_reg, gate_top_reg;
    logic [12:0] gate_cols_reg, gate_rows_reg;
    logic [15:0] thr_reg [bncs_pkg::NUM_POS];

    logic [CW-1:0] f_all_reg [bncs_pkg::NUM_POS];
    logic [CW-1:0] f_val_reg [bncs_pkg::NUM_POS];
    logic [CW-1:0] f_near_reg [bncs_pkg::NUM_POS];
    logic [CW-1:0] g_all_reg [bncs_pkg::NUM_POS];
    logic [CW-1:0] g_val_reg [bncs_pkg::NUM_POS];
    logic [CW-1:0] g_near_reg [bncs_pkg::NUM_POS];

    logic        ok_reg;
    logic [15:0] q_reg [4];
    logic [3:0]  u_reg;

    logic [1:0]  pos;
    logic        in_gate, is_near;
    logic [13:0] w, h, gl_end, gt_end;
    logic        ok_next;

    logic [CW-1:0] num, den;
    logic          d_done, d_undef;
    logic [15:0]   d_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_left_reg <= '0;
            gate_top_reg  <= '0;
            gate_cols_reg <= 13'd2;
            gate_rows_reg <= 13'd2;
            for (int i = 0; i < bncs_pkg::NUM_POS; i++)
                thr_reg[i] <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (bncs_pkg::reg_idx_t'(cfg_index))
                bncs_pkg::REG_GATE_LEFT: gate_left_reg <= cfg_data[11:0];
                bncs_pkg::REG_GATE_TOP:  gate_top_reg  <= cfg_data[11:0];
                bncs_pkg::REG_GATE_COLS: gate_cols_reg <= cfg_data[12:0];
                bncs_pkg::REG_GATE_ROWS: gate_rows_reg <= cfg_data[12:0];
                bncs_pkg::REG_THR0:      thr_reg[0]    <= cfg_data;
                bncs_pkg::REG_THR1:      thr_reg[1]    <= cfg_data;
                bncs_pkg::REG_THR2:      thr_reg[2]    <= cfg_data;
                bncs_pkg::REG_THR3:      thr_reg[3]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // gate end can reach 4095 + 8191, so one bit above the register width
    assign pos     = {pixel_row[0], pixel_col[0]};
    assign gl_end  = {2'b0, gate_left_reg} + {1'b0, gate_cols_reg};
    assign gt_end  = {2'b0, gate_top_reg} + {1'b0, gate_rows_reg};
    assign in_gate = (pixel_col >= gate_left_reg) && ({2'b0, pixel_col} < gl_end) &&
                     (pixel_row >= gate_top_reg) && ({2'b0, pixel_row} < gt_end);
    assign is_near = (pixel_value >= thr_reg[pos]);
    assign w       = {2'b0, pixel_col} + 14'd1;
    assign h       = {2'b0, pixel_row} + 14'd1;
    assign ok_next = !w[0] && !h[0] && (w >= 14'd2) && (h >= 14'd2) &&
                     (w <= 14'(bncs_pkg::MAX_DIM)) && (h <= 14'(bncs_pkg::MAX_DIM)) &&
                     !gate_left_reg[0] && !gate_top_reg[0] &&
                     !gate_cols_reg[0] && !gate_rows_reg[0] &&
                     (gate_cols_reg != '0) && (gate_rows_reg != '0) &&
                     (gl_end <= w) && (gt_end <= h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bncs_pkg::NUM_POS; i++)
            begin
                f_all_reg[i] <= '0; f_val_reg[i] <= '0; f_near_reg[i] <= '0;
                g_all_reg[i] <= '0; g_val_reg[i] <= '0; g_near_reg[i] <= '0;
            end
            ok_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < bncs_pkg::NUM_POS; i++)
            begin
                f_all_reg[i] <= '0; f_val_reg[i] <= '0; f_near_reg[i] <= '0;
                g_all_reg[i] <= '0; g_val_reg[i] <= '0; g_near_reg[i] <= '0;
            end
        end
        else if (cmd.count_en)
        begin
            f_all_reg[pos] <= bncs_pkg::sat_inc(f_all_reg[pos]);
            if (in_gate)
                g_all_reg[pos] <= bncs_pkg::sat_inc(g_all_reg[pos]);
            if (sample_valid)
            begin
                f_val_reg[pos] <= bncs_pkg::sat_inc(f_val_reg[pos]);
                if (in_gate)
                    g_val_reg[pos] <= bncs_pkg::sat_inc(g_val_reg[pos]);
                if (is_near)
                begin
                    f_near_reg[pos] <= bncs_pkg::sat_inc(f_near_reg[pos]);
                    if (in_gate)
                        g_near_reg[pos] <= bncs_pkg::sat_inc(g_near_reg[pos]);
                end
            end
            if (cmd.capture_last)
                ok_reg <= ok_next;
        end
    end

    always_comb
    begin
        unique case (cmd.ratio_sel)
            2'd0:    begin num = f_near_reg[cmd.pos]; den = f_val_reg[cmd.pos]; end
            2'd1:    begin num = g_near_reg[cmd.pos]; den = g_val_reg[cmd.pos]; end
            2'd2:    begin num = f_val_reg[cmd.pos];  den = f_all_reg[cmd.pos]; end
            default: begin num = g_val_reg[cmd.pos];  den = g_all_reg[cmd.pos]; end
        endcase
    end

    bncs_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load_div),
        .num   (num),
        .den   (den),
        .done  (d_done),
        .quo   (d_quo),
        .undef (d_undef)
    );

    assign sts.div_done = d_done;

    always_ff @(posedge clk)
    begin
        if (cmd.store_q)
        begin
            q_reg[cmd.ratio_sel] <= d_quo;
            u_reg[cmd.ratio_sel] <= d_undef;
        end
        if (cmd.out_load)
        begin
            out_data <= ok_reg ?
                {{2{1'b0}}, u_reg[3], u_reg[2], u_reg[1], u_reg[0],
                 q_reg[3], q_reg[2], q_reg[1], q_reg[0], cmd.pos} :
                {{2{1'b0}}, 4'hF, 64'd0, cmd.pos};
            out_user <= !ok_reg;
            out_last <= (cmd.pos == 2'd3);
        end
    end
endmodule

// ----- sv/bncs_control.sv -----
// Controller: sequences pixel accumulation, the end-of-frame divisions and result transfers.
module bncs_control
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           in_last,
    input  logic           out_free,
    input  bncs_pkg::sts_t sts,
    output bncs_pkg::cmd_t cmd,
    output logic           in_ready,
    output logic           out_set
);
    bncs_pkg::state_t state_reg, state_next;
    logic [1:0] pos_reg, pos_next, sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bncs_pkg::ST_ACCUM;
            pos_reg   <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.pos    = pos_reg;
        cmd.ratio_sel = sel_reg;
        in_ready   = 1'b0;
        out_set    = 1'b0;
        unique case (state_reg)
            bncs_pkg::ST_ACCUM:
            begin
                in_ready     = 1'b1;
                cmd.count_en = in_fire;
                cmd.capture_last = in_fire && in_last;
                if (in_fire && in_last)
                begin
                    state_next = bncs_pkg::ST_LOAD;
                    pos_next   = '0;
                    sel_next   = '0;
                end
            end
            bncs_pkg::ST_LOAD:
            begin
                cmd.load_div = 1'b1;
                state_next   = bncs_pkg::ST_DIV;
            end
            bncs_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.store_q = 1'b1;
                    state_next  = (sel_reg == 2'd3) ? bncs_pkg::ST_EMIT : bncs_pkg::ST_LOAD;
                    sel_next    = sel_reg + 1'b1;
                end
            end
            bncs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_set      = 1'b1;
                    state_next   = bncs_pkg::ST_NEXT;
                end
            end
            bncs_pkg::ST_NEXT:
            begin
                if (pos_reg == 2'd3)
                begin
                    cmd.clear  = 1'b1;
                    state_next = bncs_pkg::ST_ACCUM;
                end
                else
                    state_next = bncs_pkg::ST_LOAD;
                pos_next = pos_reg + 1'b1;
            end
            default: state_next = bncs_pkg::ST_ACCUM;
        endcase
    end
endmodule
